// ----- hdl/b64dd_pkg.sv -----
// b64dd_pkg: types, codes and helper functions for the base64 digest decoder
// no dependencies; imported by base64_digest_decoder_unit
`timescale 1ns / 1ps

package b64dd_pkg;

	localparam logic [15:0] CHAR_SPACE = 16'h0020;
	localparam logic [15:0] CHAR_TAB   = 16'h0009;
	localparam logic [15:0] CHAR_CR    = 16'h000D;
	localparam logic [15:0] CHAR_LF    = 16'h000A;
	localparam logic [15:0] CHAR_PAD   = 16'h003D;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
	localparam logic [1:0] STATUS_MISMATCH = 2'd2;

	localparam logic [6:0] EXPECTED_BYTES_RESET = 7'd32;
	localparam logic [6:0] COUNT_MAX            = 7'd127;
	localparam logic [1:0] PAD_MAX              = 2'd3;

	typedef struct packed {
		logic       valid;
		logic [5:0] value;
	} sextet_t;

	typedef struct packed {
		logic [7:0] chars;
		logic [1:0] pads;
	} length_rule_t;

	function automatic sextet_t sextet_of(input logic [15:0] c);
		sextet_t s;
		s.valid = 1'b1;
		s.value = 6'd0;
		if (c >= 16'h0041 && c <= 16'h005A) begin
			s.value = 6'(c - 16'h0041);
		end else if (c >= 16'h0061 && c <= 16'h007A) begin
			s.value = 6'(c - 16'h0061 + 16'd26);
		end else if (c >= 16'h0030 && c <= 16'h0039) begin
			s.value = 6'(c - 16'h0030 + 16'd52);
		end else if (c == 16'h002B) begin
			s.value = 6'd62;
		end else if (c == 16'h002F) begin
			s.value = 6'd63;
		end else begin
			s.valid = 1'b0;
		end
		return s;
	endfunction

	// n/3 by reciprocal 43/128, exact for n below 128
	function automatic length_rule_t length_rule(input logic [6:0] n);
		logic [12:0]  prod;
		logic [5:0]   q;
		logic [1:0]   r;
		length_rule_t lr;
		prod     = 13'(n) * 13'd43;
		q        = prod[12:7];
		r        = 2'(n - 7'(q) * 7'd3);
		lr.chars = {q + 6'(r != 2'd0), 2'b00};
		lr.pads  = (r == 2'd0) ? 2'd0 : 2'(2'd3 - r);
		return lr;
	endfunction

endpackage

// ----- hdl/base64_digest_decoder_unit.sv -----
// base64_digest_decoder_unit: streaming base64 decoder with length and padding verdict
// depends on b64dd_pkg
`timescale 1ns / 1ps

// Takes one 16-bit character per transaction and accepts a new one every clock
// cycle. A character passes an input register, then the decode and verdict logic
// updates the text state and loads the result register. A result is produced
// when a byte completes or the character carries end_of_text; other characters
// give none. The result register decouples the sides, so a stalled output only
// holds the input once a waiting character would itself produce a result.
// expected_bytes is to be written through the cfg channel only while the block is
// idle; the block itself does not enforce this. It resets to 32.
module base64_digest_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] char_code,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        byte_valid,
	output logic [7:0]  byte_value,
	output logic        is_final,
	output logic [1:0]  status
);
	import b64dd_pkg::*;

	logic [6:0]   expected_bytes_q;
	length_rule_t rule_q;

	logic         valid_s1;
	logic [15:0]  char_s1;
	logic         eot_s1;

	logic [11:0]  acc_q;
	logic [2:0]   pending_q;
	logic [1:0]   pad_q;
	logic [6:0]   char_count_q;
	logic [6:0]   byte_count_q;
	logic         bad_q;

	logic         out_valid_q;
	logic         byte_valid_q;
	logic [7:0]   byte_value_q;
	logic         is_final_q;
	logic [1:0]   status_q;

	sextet_t      sx;
	logic         is_space;
	logic [11:0]  acc_n;
	logic [2:0]   pending_n;
	logic [1:0]   pad_n;
	logic [6:0]   char_count_n;
	logic [6:0]   byte_count_n;
	logic         bad_n;
	logic         have_byte;
	logic [7:0]   byte_n;
	logic [3:0]   pend_sum;
	logic [5:0]   leftover;
	logic [1:0]   status_n;
	logic         produces;
	logic         advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_bytes_q <= EXPECTED_BYTES_RESET;
			rule_q           <= length_rule(EXPECTED_BYTES_RESET);
		end else if (cfg_valid && cfg_ready) begin
			expected_bytes_q <= cfg_data;
			rule_q           <= length_rule(cfg_data);
		end
	end

	always_comb begin
		sx           = sextet_of(char_s1);
		is_space     = (char_s1 == CHAR_SPACE) || (char_s1 == CHAR_TAB) ||
			       (char_s1 == CHAR_CR) || (char_s1 == CHAR_LF);
		acc_n        = acc_q;
		pending_n    = pending_q;
		pad_n        = pad_q;
		char_count_n = char_count_q;
		byte_count_n = byte_count_q;
		bad_n        = bad_q;
		have_byte    = 1'b0;
		byte_n       = 8'd0;
		pend_sum     = 4'(pending_q) + 4'd6;
		if (!is_space) begin
			if (char_count_q != COUNT_MAX) begin
				char_count_n = char_count_q + 7'd1;
			end
			if (char_s1 == CHAR_PAD) begin
				if (pad_q != PAD_MAX) begin
					pad_n = pad_q + 2'd1;
				end
			end else if (!sx.valid || pad_q != 2'd0) begin
				bad_n = 1'b1;
			end else if (!bad_q) begin
				acc_n = {acc_q[5:0], sx.value};
				if (pend_sum >= 4'd8) begin
					pending_n = 3'(pend_sum - 4'd8);
					have_byte = 1'b1;
					case (pending_n)
						3'd0:    byte_n = acc_n[7:0];
						3'd2:    byte_n = acc_n[9:2];
						3'd4:    byte_n = acc_n[11:4];
						default: byte_n = acc_n[7:0];
					endcase
					if (byte_count_q != COUNT_MAX) begin
						byte_count_n = byte_count_q + 7'd1;
					end
				end else begin
					pending_n = 3'(pend_sum);
				end
			end
		end
	end

	always_comb begin
		case (pending_n)
			3'd2:    leftover = {4'd0, acc_n[1:0]};
			3'd4:    leftover = {2'd0, acc_n[3:0]};
			3'd6:    leftover = acc_n[5:0];
			default: leftover = 6'd0;
		endcase
		if (bad_n) begin
			status_n = STATUS_BAD_CHAR;
		end else if (byte_count_n != expected_bytes_q ||
			     {1'b0, char_count_n} != rule_q.chars ||
			     pad_n != rule_q.pads || leftover != 6'd0) begin
			status_n = STATUS_MISMATCH;
		end else begin
			status_n = STATUS_OK;
		end
	end

	assign produces = have_byte || eot_s1;
	assign advance  = valid_s1 && (!produces || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_code;
			eot_s1  <= end_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q        <= 12'd0;
			pending_q    <= 3'd0;
			pad_q        <= 2'd0;
			char_count_q <= 7'd0;
			byte_count_q <= 7'd0;
			bad_q        <= 1'b0;
		end else if (advance) begin
			if (eot_s1) begin
				acc_q        <= 12'd0;
				pending_q    <= 3'd0;
				pad_q        <= 2'd0;
				char_count_q <= 7'd0;
				byte_count_q <= 7'd0;
				bad_q        <= 1'b0;
			end else begin
				acc_q        <= acc_n;
				pending_q    <= pending_n;
				pad_q        <= pad_n;
				char_count_q <= char_count_n;
				byte_count_q <= byte_count_n;
				bad_q        <= bad_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && produces) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produces) begin
			byte_valid_q <= have_byte;
			byte_value_q <= byte_n;
			is_final_q   <= eot_s1;
			status_q     <= eot_s1 ? status_n : STATUS_OK;
		end
	end

	assign out_valid  = out_valid_q;
	assign byte_valid = byte_valid_q;
	assign byte_value = byte_value_q;
	assign is_final   = is_final_q;
	assign status     = status_q;

	// bits left over are always an even count of at most six
	a_pending_even: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q[0] == 1'b0)
		else $error("pending bit count odd");

	// every transaction out carries a byte or a verdict
	a_out_content: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (byte_valid_q || is_final_q))
		else $error("empty result");

	// status is only non-zero on a verdict
	a_status_final: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !is_final_q) |-> (status_q == STATUS_OK))
		else $error("status without verdict");

	// a verdict leaves the text state cleared
	a_clear_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && eot_s1) |=> (char_count_q == 7'd0 && byte_count_q == 7'd0 &&
			pad_q == 2'd0 && !bad_q && pending_q == 3'd0))
		else $error("text state not cleared");

	// an error stops further bytes
	a_no_byte_after_error: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && bad_q) |-> !have_byte)
		else $error("byte after error");

endmodule

// ----- sim/tb_top.sv -----
// tb_top: self-checking testbench for base64_digest_decoder_unit
// depends on b64dd_pkg and base64_digest_decoder_unit; predicts every result transaction
`timescale 1ns / 1ps

module tb_top;

	import b64dd_pkg::*;

	typedef struct packed {
		logic       byte_valid;
		logic [7:0] byte_value;
		logic       is_final;
		logic [1:0] status;
	} digest_result_t;

	typedef struct packed {
		logic [15:0]    c;
		logic           eot;
		logic           typed;
		digest_result_t want;
	} text_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [6:0]  cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [15:0] char_code = '0;
	logic        end_of_text = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        byte_valid;
	logic [7:0]  byte_value;
	logic        is_final;
	logic [1:0]  status;

	// decoder state as predicted
	logic [6:0]  digest_len = EXPECTED_BYTES_RESET;
	logic [11:0] acc_bits = '0;
	int          held_bits = 0;
	logic [1:0]  pads_seen = '0;
	logic [6:0]  chars_seen = '0;
	logic [6:0]  bytes_seen = '0;
	logic        text_bad = 1'b0;

	digest_result_t results_due[$];
	int errors = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	bit hold_start = 1'b0;
	int hold_left = 0;

	base64_digest_decoder_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.char_code  (char_code),
		.end_of_text(end_of_text),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.byte_valid (byte_valid),
		.byte_value (byte_value),
		.is_final   (is_final),
		.status     (status)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("tb_top failed");
		$finish;
	end

	function automatic bit is_blank(input logic [15:0] c);
		return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR || c == CHAR_LF;
	endfunction

	function automatic logic [15:0] any_blank();
		case ($urandom_range(3))
			0: return CHAR_SPACE;
			1: return CHAR_TAB;
			2: return CHAR_CR;
			default: return CHAR_LF;
		endcase
	endfunction

	// -1 for anything outside the alphabet
	function automatic int sextet_value(input logic [15:0] c);
		int d;
		d = -1;
		if (c >= "A" && c <= "Z")
			d = int'(c - "A");
		else if (c >= "a" && c <= "z")
			d = int'(c - "a") + 26;
		else if (c >= "0" && c <= "9")
			d = int'(c - "0") + 52;
		else if (c == "+")
			d = 62;
		else if (c == "/")
			d = 63;
		return d;
	endfunction

	function automatic logic [15:0] sextet_char(input logic [5:0] v);
		if (v < 26)
			return 16'h0041 + v;
		else if (v < 52)
			return 16'h0061 + v - 26;
		else if (v < 62)
			return 16'h0030 + v - 52;
		else if (v == 62)
			return 16'h002B;
		return 16'h002F;
	endfunction

	function automatic bit decode_char(input logic [15:0] c, input logic eot,
			output digest_result_t r);
		int d;
		int want_chars;
		int want_pads;
		r = '0;
		if (!is_blank(c)) begin
			if (chars_seen != COUNT_MAX)
				chars_seen++;
			if (c == CHAR_PAD) begin
				if (pads_seen != PAD_MAX)
					pads_seen++;
			end else begin
				d = sextet_value(c);
				if (d < 0 || pads_seen != 0) begin
					text_bad = 1'b1;
				end else if (!text_bad) begin
					acc_bits = {acc_bits[5:0], d[5:0]};
					held_bits += 6;
					if (held_bits >= 8) begin
						held_bits -= 8;
						r.byte_valid = 1'b1;
						r.byte_value = 8'(acc_bits >> held_bits);
						if (bytes_seen != COUNT_MAX)
							bytes_seen++;
					end
				end
			end
		end
		if (eot) begin
			want_chars = (digest_len + 2) / 3 * 4;
			want_pads = (3 - digest_len % 3) % 3;
			r.is_final = 1'b1;
			if (text_bad)
				r.status = STATUS_BAD_CHAR;
			else if (bytes_seen != digest_len || chars_seen != want_chars ||
					pads_seen != want_pads ||
					(acc_bits & ((12'd1 << held_bits) - 12'd1)) != 12'd0)
				r.status = STATUS_MISMATCH;
			else
				r.status = STATUS_OK;
			acc_bits = '0;
			held_bits = 0;
			pads_seen = '0;
			chars_seen = '0;
			bytes_seen = '0;
			text_bad = 1'b0;
		end
		return r.byte_valid || eot;
	endfunction

	function automatic text_row_t plain(input logic [15:0] c, input logic eot);
		text_row_t row;
		row = '0;
		row.c = c;
		row.eot = eot;
		return row;
	endfunction

	// verdict rows whose result is known without working through the decode
	function automatic text_row_t verdict(input logic [15:0] c, input logic bv,
			input logic [7:0] bval, input logic [1:0] st);
		text_row_t row;
		row.c = c;
		row.eot = 1'b1;
		row.typed = 1'b1;
		row.want.byte_valid = bv;
		row.want.byte_value = bval;
		row.want.is_final = 1'b1;
		row.want.status = st;
		return row;
	endfunction

	task automatic send_char(input logic [15:0] c, input logic eot, input logic typed,
			input digest_result_t want);
		digest_result_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		char_code <= c;
		end_of_text <= eot;
		do @(posedge clk); while (!in_ready);
		if (decode_char(c, eot, r)) begin
			if (typed)
				results_due.insert(results_due.size(), want);
			else
				results_due.insert(results_due.size(), r);
		end
	endtask

	task automatic set_digest_len(input logic [6:0] v);
		in_valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		// characters without a result may still be in the pipeline
		repeat (4) @(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		digest_len = v;
	endtask

	// mostly well-formed encodings of random bytes, with some corrupted texts and noise
	task automatic send_text(output int nsent);
		logic [15:0] chars[$];
		logic [23:0] group;
		int kind;
		int nbytes;
		int left;
		kind = $urandom_range(99);
		nbytes = int'(digest_len);
		if (kind >= 80 && kind < 85)
			nbytes = $urandom_range(digest_len + 2);
		if (kind >= 95) begin
			repeat ($urandom_range(8)) begin
				if ($urandom_range(1) == 1)
					chars.insert(chars.size(), 16'($urandom_range(65535)));
				else
					chars.insert(chars.size(), 16'($urandom_range(32, 127)));
			end
		end else begin
			for (int i = 0; i < nbytes; i += 3) begin
				left = nbytes - i;
				group = 24'($urandom_range(16777215));
				if (left < 3)
					group[7:0] = '0;
				if (left < 2)
					group[15:8] = '0;
				if (kind >= 85 && kind < 90) begin
					if (left == 1)
						group[12] = 1'b1;
					else if (left == 2)
						group[6] = 1'b1;
				end
				chars.insert(chars.size(), sextet_char(group[23:18]));
				chars.insert(chars.size(), sextet_char(group[17:12]));
				chars.insert(chars.size(), left >= 2 ? sextet_char(group[11:6]) : CHAR_PAD);
				chars.insert(chars.size(), left >= 3 ? sextet_char(group[5:0]) : CHAR_PAD);
			end
			if (kind >= 70 && kind < 80 && chars.size() > 0)
				chars[$urandom_range(chars.size() - 1)] = 16'($urandom_range(65535));
			if (kind >= 90)
				chars.insert(chars.size(), $urandom_range(1) == 1 ? CHAR_PAD :
					sextet_char(6'($urandom_range(63))));
		end
		if ($urandom_range(9) == 0 || chars.size() == 0)
			chars.insert(chars.size(), any_blank());
		nsent = 0;
		foreach (chars[i]) begin
			if ($urandom_range(19) == 0)
				send_char(any_blank(), 1'b0, 1'b0, '0);
			send_char(chars[i], i == chars.size() - 1, 1'b0, '0);
			nsent++;
		end
	endtask

	initial begin : rx_side
		forever begin
			@(posedge clk);
			if (hold_start) begin
				hold_start = 1'b0;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin : result_check
		digest_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (results_due.size() == 0) begin
				$error("result transaction with none expected");
				errors++;
			end else begin
				want = results_due.pop_front();
				if (byte_valid !== want.byte_valid) begin
					$error("byte_valid: expected %0d, got %0d", want.byte_valid, byte_valid);
					errors++;
				end
				if (byte_value !== want.byte_value) begin
					$error("byte_value: expected %0h, got %0h", want.byte_value, byte_value);
					errors++;
				end
				if (is_final !== want.is_final) begin
					$error("is_final: expected %0d, got %0d", want.is_final, is_final);
					errors++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					errors++;
				end
			end
		end
	end

	initial begin : stimulus
		text_row_t   rows[$];
		logic [6:0]  phase_len [0:7];
		int          sent;
		int          n;
		rows = '{
			plain(16'("A"), 1'b0), plain(16'("Z"), 1'b0), plain(16'("a"), 1'b0),
			plain(16'("z"), 1'b0), plain(16'("0"), 1'b0), plain(16'("9"), 1'b0),
			plain(16'("+"), 1'b0), plain(16'("/"), 1'b0),
			plain(CHAR_SPACE, 1'b0), plain(CHAR_TAB, 1'b0), plain(CHAR_CR, 1'b0),
			verdict(CHAR_LF, 1'b0, 8'h00, STATUS_MISMATCH),
			plain(16'h0000, 1'b0),
			verdict(16'("Q"), 1'b0, 8'h00, STATUS_BAD_CHAR),
			verdict(16'hFFFF, 1'b0, 8'h00, STATUS_BAD_CHAR),
			plain(16'("T"), 1'b0), plain(16'("Q"), 1'b0), plain(CHAR_PAD, 1'b0),
			verdict(16'("A"), 1'b0, 8'h00, STATUS_BAD_CHAR),
			verdict(CHAR_PAD, 1'b0, 8'h00, STATUS_MISMATCH),
			verdict(CHAR_SPACE, 1'b0, 8'h00, STATUS_MISMATCH),
			verdict(16'("@"), 1'b0, 8'h00, STATUS_BAD_CHAR),
			plain(16'("A"), 1'b0), plain(16'("A"), 1'b0),
			verdict(16'("A"), 1'b1, 8'h00, STATUS_MISMATCH)
		};
		phase_len = '{7'd32, 7'd1, 7'd2, 7'd64, 7'd0, 7'd127, 7'd3, 7'd0};
		phase_len[7] = 7'($urandom_range(1, 64));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send_char(rows[i].c, rows[i].eot, rows[i].typed, rows[i].want);

		for (int p = 0; p < 8; p++) begin
			// first phase keeps the reset length
			if (p != 0)
				set_digest_len(phase_len[p]);
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 80;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 80;
				end
				default: begin
					send_idle_pct = 6;
					stall_pct = 6;
				end
			endcase
			if (p == 0)
				hold_start = 1'b1;
			sent = 0;
			while (sent < 120) begin
				send_text(n);
				sent += n;
			end
		end

		in_valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
